>>> sv/sp2c_pkg.sv
// Shared types, constants and the quarter-wave sine table for the scan converter.
package sp2c_pkg;

  // Table and field geometry.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TAB_ENTRIES      = SINE_TABLE_DEPTH + 1;
  localparam int IDX_W            = $clog2(TAB_ENTRIES);
  localparam int MAG_W            = 16;
  localparam int RANGE_W          = 16;
  localparam int ANGLE_W          = 16;
  localparam int COORD_W          = 17;
  localparam int PROD_W           = RANGE_W + MAG_W;
  localparam int FRAC_W           = ANGLE_W - 2;
  localparam int CFG_IDX_W        = 2;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_START_ANGLE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ANGLE_STEP  = cfg_idx_t'(1);

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t sine_tab_t [0:SINE_TABLE_DEPTH];

  // Table lookup for one ray: quadrant and the two table indexes.
  typedef struct packed {
    logic [1:0]       quad;
    logic [IDX_W-1:0] idx_sin;
    logic [IDX_W-1:0] idx_cos;
  } lookup_t;

  // One table entry: sine of a quarter-turn fraction, Q1.15, via a Q2.30 series.
  function automatic mag_t quarter_sine(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = (64'd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    // Eight alternating correction terms; term k is divided by (2k)(2k+1).
    term = ((x * x2) >> 30) / 64'd6;
    sum  = longint'(x) - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return MAG_W'(v);
  endfunction

  // Whole table, evaluated at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

>>> sv/sp2c_ram.sv
// Generic RAM with one write port and two registered read ports.
module sp2c_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; data holds while the read enable is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> sv/sp2c_sine_tab.sv
// Sine table memory with its fill sequencer after reset.
module sp2c_sine_tab
  import sp2c_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  lookup_t lookup,
  output logic    busy,
  output mag_t    mag_sin,
  output mag_t    mag_cos
);

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_RUN  = 2'b10
  } fill_state_t;

  fill_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             fill_we;

  // Fill sweep: one table entry written per cycle.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fill_we   = 1'b0;
    case (state_r)
      ST_FILL: begin
        fill_we = 1'b1;
        if (cnt_r == IDX_W'(SINE_TABLE_DEPTH)) begin
          state_nxt = ST_RUN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_RUN: begin
        fill_we = 1'b0;
      end
      default: begin
        state_nxt = ST_FILL;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_RUN);

  sp2c_ram #(
    .WIDTH (MAG_W),
    .DEPTH (TAB_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (cnt_r),
    .wdata   (SINE_TAB[cnt_r]),
    .rd_en   (rd_en),
    .raddr_a (lookup.idx_sin),
    .raddr_b (lookup.idx_cos),
    .rdata_a (mag_sin),
    .rdata_b (mag_cos)
  );

endmodule

>>> sv/sp2c_angle.sv
// Configuration registers, running ray angle and table index generation.
module sp2c_angle
  import sp2c_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  cfg_idx_t           cfg_index,
  input  logic [ANGLE_W-1:0] cfg_data,
  input  logic               accept,
  input  logic               scan_start,
  output lookup_t            lookup
);

  localparam int NPROD_W = FRAC_W + IDX_W + 1;

  logic [ANGLE_W-1:0] start_angle_r, start_angle_nxt;
  logic [ANGLE_W-1:0] angle_step_r, angle_step_nxt;
  logic [ANGLE_W-1:0] ray_angle_r, ray_angle_nxt;
  logic [ANGLE_W-1:0] cur_angle;
  logic [NPROD_W-1:0] n_wide;
  logic [IDX_W-1:0]   n_idx;

  // Register writes.
  always_comb begin
    start_angle_nxt = start_angle_r;
    angle_step_nxt  = angle_step_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_START_ANGLE: start_angle_nxt = cfg_data;
        REG_ANGLE_STEP:  angle_step_nxt  = cfg_data;
        default: begin
          start_angle_nxt = start_angle_r;
        end
      endcase
    end
  end

  // Scan start reloads the angle; every accepted ray advances it.
  assign cur_angle     = scan_start ? start_angle_r : ray_angle_r;
  assign ray_angle_nxt = accept ? (cur_angle + angle_step_r) : ray_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      ray_angle_r   <= '0;
    end else begin
      start_angle_r <= start_angle_nxt;
      angle_step_r  <= angle_step_nxt;
      ray_angle_r   <= ray_angle_nxt;
    end
  end

  // Map the in-quadrant fraction to a rounded table index.
  assign n_wide = (NPROD_W'(cur_angle[FRAC_W-1:0]) * NPROD_W'(SINE_TABLE_DEPTH)
                   + NPROD_W'(1 << (FRAC_W - 1))) >> FRAC_W;
  assign n_idx  = (n_wide > NPROD_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH)
                                                         : n_wide[IDX_W-1:0];

  assign lookup.quad    = cur_angle[ANGLE_W-1:ANGLE_W-2];
  assign lookup.idx_sin = n_idx;
  assign lookup.idx_cos = IDX_W'(SINE_TABLE_DEPTH) - n_idx;

endmodule

>>> sv/scan_polar_to_cartesian_core.sv
// Scan converter top level: ray range in, angle from the configured start and step, rounded x/y point out.
// A ray passes registered stages in order: table read, multiply, then round and sign;
// out_stall can hold each stage.
// Throughput is one ray per cycle while out_stall is low, set by the dual-read sine table memory.
// After reset all 1025 table entries are filled, with in_stall held high.
// Reset clears the configuration registers, the running angle and all valid flags.
module scan_polar_to_cartesian_core
  import sp2c_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cfg_idx_t                  cfg_index,
  input  logic [ANGLE_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RANGE_W-1:0]        in_range_mm,
  input  logic                      in_no_return,
  input  logic                      in_scan_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x_mm,
  output logic signed [COORD_W-1:0] out_y_mm
);

  lookup_t            lookup;
  logic               tab_busy;
  mag_t               mag_sin, mag_cos;
  logic               in_accept;
  logic               s1_ready, s2_ready, out_load;

  logic               s1_valid_r, s1_valid_nxt;
  logic [RANGE_W-1:0] s1_range_r;
  logic [1:0]         s1_quad_r;

  logic               s2_valid_r, s2_valid_nxt;
  logic [PROD_W-1:0]  s2_prod_x_r, s2_prod_y_r;
  logic               s2_neg_x_r, s2_neg_y_r;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r, out_y_r;

  mag_t               smag, cmag;
  logic [PROD_W:0]    rnd_x, rnd_y;
  logic [COORD_W-1:0] m_x, m_y;

  assign cfg_ready = 1'b1;

  // Per-stage flow control: a stage loads when it is empty or drains.
  assign out_load  = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_load;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = tab_busy || !s1_ready;
  assign in_accept = in_valid && !in_stall;

  sp2c_angle u_angle (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (in_accept),
    .scan_start (in_scan_start),
    .lookup     (lookup)
  );

  sp2c_sine_tab u_sine_tab (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_ready),
    .lookup  (lookup),
    .busy    (tab_busy),
    .mag_sin (mag_sin),
    .mag_cos (mag_cos)
  );

  // Stage 1: table read in flight; rays without a return carry no point.
  assign s1_valid_nxt = s1_ready ? (in_accept && !in_no_return) : s1_valid_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_range_r <= in_range_mm;
      s1_quad_r  <= lookup.quad;
    end
  end

  // Stage 2: quadrant folding and the two products.
  assign smag         = s1_quad_r[0] ? mag_cos : mag_sin;
  assign cmag         = s1_quad_r[0] ? mag_sin : mag_cos;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_prod_x_r <= PROD_W'(s1_range_r) * PROD_W'(cmag);
      s2_prod_y_r <= PROD_W'(s1_range_r) * PROD_W'(smag);
      s2_neg_x_r  <= s1_quad_r[1] ^ s1_quad_r[0];
      s2_neg_y_r  <= s1_quad_r[1];
    end
  end

  // Output stage: round to nearest millimetre and apply the sign.
  assign rnd_x         = {1'b0, s2_prod_x_r} + (PROD_W + 1)'(1 << (MAG_W - 2));
  assign rnd_y         = {1'b0, s2_prod_y_r} + (PROD_W + 1)'(1 << (MAG_W - 2));
  assign m_x           = rnd_x[COORD_W + MAG_W - 2:MAG_W - 1];
  assign m_y           = rnd_y[COORD_W + MAG_W - 2:MAG_W - 1];
  assign out_valid_nxt = out_load ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= s2_neg_x_r ? (COORD_W'(0) - m_x) : m_x;
      out_y_r <= s2_neg_y_r ? (COORD_W'(0) - m_y) : m_y;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_mm  = out_x_r;
  assign out_y_mm  = out_y_r;

endmodule

>>> tb/tb_scan_polar_to_cartesian_core.sv
// Testbench for the scan converter: directed and random rays checked against a predictor.
module tb_scan_polar_to_cartesian_core;
  import sp2c_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_RAYS    = 480;

  // Register indexes that the block does not decode.
  localparam cfg_idx_t REG_UNUSED_LO = cfg_idx_t'(2);
  localparam cfg_idx_t REG_UNUSED_HI = cfg_idx_t'(3);

  // Quadrant of a ray angle, from its top two bits.
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  cfg_idx_t                  cfg_index;
  logic [ANGLE_W-1:0]        cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [RANGE_W-1:0]        in_range_mm;
  logic                      in_no_return;
  logic                      in_scan_start;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_x_mm;
  logic signed [COORD_W-1:0] out_y_mm;

  // Predictor state: register copies, running heading and the sine table.
  logic [ANGLE_W-1:0] scan_origin;
  logic [ANGLE_W-1:0] heading_step;
  logic [ANGLE_W-1:0] heading;
  mag_t               quarter_wave [0:SINE_TABLE_DEPTH];
  point_t             pending_points [$];

  int unsigned failures   = 0;
  int unsigned rays_sent  = 0;
  int unsigned hold_left  = 0;
  bit          no_idle    = 1'b0;

  scan_polar_to_cartesian_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_range_mm   (in_range_mm),
    .in_no_return  (in_no_return),
    .in_scan_start (in_scan_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x_mm      (out_x_mm),
    .out_y_mm      (out_y_mm)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sine of a quarter-turn fraction in Q1.15, from a Q2.30 alternating series.
  function automatic mag_t sine_entry(int unsigned i);
    longint unsigned arg;
    longint unsigned arg_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    arg    = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
    arg_sq = (arg * arg) >> 30;
    term   = arg;
    acc    = longint'(arg);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * arg_sq) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (64'(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32768) begin
      rounded = 64'd32768;
    end
    return mag_t'(rounded);
  endfunction

  // Range times a Q1.15 magnitude, rounded to nearest, with the sign applied.
  function automatic logic signed [COORD_W-1:0] scale_coord(logic [RANGE_W-1:0] len_mm,
                                                            mag_t mag, bit neg);
    logic [31:0] prod;
    prod = (32'(len_mm) * 32'(mag) + 32'd16384) >> 15;
    return neg ? -COORD_W'(prod) : COORD_W'(prod);
  endfunction

  // Predicts the point of one accepted ray and advances the heading.
  function automatic void predict_ray(logic [RANGE_W-1:0] len_mm, bit miss, bit first);
    int unsigned n;
    mag_t        a;
    mag_t        b;
    point_t      pt;
    if (first) begin
      heading = scan_origin;
    end
    if (!miss) begin
      n = (32'(heading[FRAC_W-1:0]) * 32'(SINE_TABLE_DEPTH) + 32'd8192) >> 14;
      if (n > SINE_TABLE_DEPTH) begin
        n = SINE_TABLE_DEPTH;
      end
      a = quarter_wave[n];
      b = quarter_wave[SINE_TABLE_DEPTH - n];
      case (heading[ANGLE_W-1 -: 2])
        QUAD_FIRST: begin
          pt.x = scale_coord(len_mm, b, 1'b0);
          pt.y = scale_coord(len_mm, a, 1'b0);
        end
        QUAD_SECOND: begin
          pt.x = scale_coord(len_mm, a, 1'b1);
          pt.y = scale_coord(len_mm, b, 1'b0);
        end
        QUAD_THIRD: begin
          pt.x = scale_coord(len_mm, b, 1'b1);
          pt.y = scale_coord(len_mm, a, 1'b1);
        end
        default: begin
          pt.x = scale_coord(len_mm, a, 1'b0);
          pt.y = scale_coord(len_mm, b, 1'b1);
        end
      endcase
      pending_points.insert(pending_points.size(), pt);
    end
    heading = heading + heading_step;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Range with its extremes weighted up.
  function automatic logic [RANGE_W-1:0] pick_range();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return RANGE_W'($urandom_range(0, 65535));
  endfunction

  // Sends one ray transaction, records its prediction, then idles at random.
  task automatic send_ray(logic [RANGE_W-1:0] len_mm, bit miss, bit first);
    int unsigned gap;
    in_range_mm   <= len_mm;
    in_no_return  <= miss;
    in_scan_start <= first;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    predict_ray(len_mm, miss, first);
    rays_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes one register; keep_valid leaves the channel up for a following write.
  task automatic write_reg(cfg_idx_t idx, logic [ANGLE_W-1:0] value, bit keep_valid = 1'b0);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) begin
      @(posedge clk);
    end
    if (!keep_valid) begin
      cfg_valid <= 1'b0;
    end
    if (idx == REG_START_ANGLE) begin
      scan_origin = value;
    end else if (idx == REG_ANGLE_STEP) begin
      heading_step = value;
    end
  endtask

  // Drops the input, waits for every expected point, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rays before any scan start use the reset heading of zero with a zero step.
  task automatic test_reset_heading();
    send_ray(16'hFFFF, 1'b0, 1'b0);
    send_ray(16'h0000, 1'b0, 1'b0);
    send_ray(16'd1234, 1'b1, 1'b0);
    wait_idle();
  endtask

  // Quarter-turn steps visit every quadrant and wrap back to the start.
  task automatic test_quadrants();
    write_reg(REG_START_ANGLE, 16'h0000, 1'b1);
    write_reg(REG_ANGLE_STEP, 16'h4000);
    send_ray(16'hFFFF, 1'b0, 1'b1);
    send_ray(16'hFFFF, 1'b0, 1'b0);
    send_ray(16'hFFFF, 1'b0, 1'b0);
    send_ray(16'hFFFF, 1'b0, 1'b0);
    send_ray(16'h0001, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Register extremes and angles just below each quadrant boundary.
  task automatic test_extreme_settings();
    write_reg(REG_START_ANGLE, 16'hFFFF, 1'b1);
    write_reg(REG_ANGLE_STEP, 16'h8000);
    send_ray(16'hFFFF, 1'b0, 1'b1);
    send_ray(16'hFFFF, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_START_ANGLE, 16'h3FFF, 1'b1);
    write_reg(REG_ANGLE_STEP, 16'h7FFF);
    send_ray(16'hFFFF, 1'b0, 1'b1);
    send_ray(16'h8001, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Rays with no return give no point but still advance the heading.
  task automatic test_no_return();
    write_reg(REG_START_ANGLE, 16'h2000, 1'b1);
    write_reg(REG_ANGLE_STEP, 16'd100);
    send_ray(16'hFFFF, 1'b1, 1'b1);
    send_ray(16'h0000, 1'b1, 1'b0);
    send_ray(16'd40000, 1'b0, 1'b0);
    wait_idle();
  endtask

  // A new start angle waits for the next scan start; a new step applies at once.
  task automatic test_midscan_writes();
    write_reg(REG_START_ANGLE, 16'h1234);
    send_ray(16'd30000, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_ANGLE_STEP, 16'hFFFF);
    send_ray(16'd30000, 1'b0, 1'b0);
    send_ray(16'd30000, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Writes to undecoded indexes leave both registers untouched.
  task automatic test_unknown_index();
    write_reg(REG_UNUSED_LO, ANGLE_W'($urandom), 1'b1);
    write_reg(REG_UNUSED_HI, ANGLE_W'($urandom));
    send_ray(16'd5000, 1'b0, 1'b0);
    send_ray(16'd5000, 1'b0, 1'b1);
    wait_idle();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    write_reg(REG_START_ANGLE, ANGLE_W'($urandom), 1'b1);
    write_reg(REG_ANGLE_STEP, 16'd997);
    no_idle   = 1'b1;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_ray(pick_range(), ($urandom_range(0, 9) == 0), (i == 0));
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Random scans under random settings, with some broken or partial scans.
  task automatic test_random_scans();
    int unsigned first_ray;
    int unsigned scan_len;
    logic [ANGLE_W-1:0] step;
    first_ray = rays_sent;
    for (int s = 0; rays_sent - first_ray < RANDOM_RAYS; s++) begin
      if ((s % 4) == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0:       step = 16'h8000;
          1:       step = 16'h7FFF;
          2:       step = ANGLE_W'($urandom);
          default: step = ANGLE_W'($urandom_range(0, 800)) - 16'd400;
        endcase
        write_reg(REG_START_ANGLE, ANGLE_W'($urandom), 1'b1);
        write_reg(REG_ANGLE_STEP, step);
      end
      no_idle = ((s % 7) == 3);
      if ($urandom_range(0, 9) == 0) begin
        scan_len = $urandom_range(1, 4);
      end else begin
        scan_len = $urandom_range(8, 40);
      end
      for (int i = 0; i < scan_len; i++) begin
        send_ray(pick_range(), ($urandom_range(0, 9) == 0),
                 ((i == 0) && ($urandom_range(0, 9) != 0)) || ($urandom_range(0, 49) == 0));
      end
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Result-side stall: a pressure hold when requested, otherwise random bursts.
  initial begin : result_stall
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0 && !no_idle) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Each accepted point transaction is compared with the oldest prediction.
  initial begin : point_check
    point_t want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_points.size() == 0) begin
          $error("unexpected point x_mm=%0d y_mm=%0d", out_x_mm, out_y_mm);
          failures++;
        end else begin
          want = pending_points.pop_front();
          if (out_x_mm !== want.x) begin
            $error("x_mm: expected %0d, actual %0d", want.x, out_x_mm);
            failures++;
          end
          if (out_y_mm !== want.y) begin
            $error("y_mm: expected %0d, actual %0d", want.y, out_y_mm);
            failures++;
          end
        end
      end
    end
  end

  // The run ends if no transaction of any kind completes for too long.
  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Main sequence: table setup, reset, then each test in turn.
  initial begin
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      quarter_wave[i] = sine_entry(i);
    end
    scan_origin   = '0;
    heading_step  = '0;
    heading       = '0;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_START_ANGLE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_range_mm   <= '0;
    in_no_return  <= 1'b0;
    in_scan_start <= 1'b0;
    out_stall     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_heading();
    test_quadrants();
    test_extreme_settings();
    test_no_return();
    test_midscan_writes();
    test_unknown_index();
    test_backpressure();
    test_random_scans();

    if (failures == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> scan_polar_to_cartesian_core.f
sv/sp2c_pkg.sv
sv/sp2c_ram.sv
sv/sp2c_sine_tab.sv
sv/sp2c_angle.sv
sv/scan_polar_to_cartesian_core.sv
tb/tb_scan_polar_to_cartesian_core.sv
